// ===== hw/rtl/circular_list_josephus_engine_defines.svh =====
// Assertion macros for the circular list engine.
`ifndef CIRCULAR_LIST_JOSEPHUS_ENGINE_DEFINES_SVH
`define CIRCULAR_LIST_JOSEPHUS_ENGINE_DEFINES_SVH

`ifndef SYNTH

`define CLJ_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("clj assertion failed");

`define CLJ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("clj assertion failed");

`else

`define CLJ_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)

`define CLJ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== hw/rtl/clj_pkg.sv =====
`default_nettype none

package clj_pkg;

    localparam int CAPACITY   = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int OP_W       = 3;
    localparam int POS_W      = 6;
    localparam int VAL_W      = 32;
    localparam int SKIP_W     = 16;
    localparam int STAT_W     = 2;
    localparam int CNTO_W     = 6;

    localparam int CMP_W      = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;
    localparam int STEP_W     = $clog2(SKIP_W + 1);

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd2;
    localparam logic [OP_W-1:0] OP_ELIM    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MOD_GO,
        S_MOD_WAIT,
        S_RD,
        S_RD_WAIT,
        S_SHIFT,
        S_INS_WR,
        S_SW_RD0,
        S_SW_RD1,
        S_SW_WR0,
        S_SW_WR1,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [SKIP_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_rsp_t;

    // ring slot of logical element idx
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] sum;
        sum = (ADDR_W + 1)'(head) + (ADDR_W + 1)'(idx);
        if (sum >= (ADDR_W + 1)'(CAPACITY))
        begin
            sum = sum - (ADDR_W + 1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clj_if.sv =====
`default_nettype none

interface clj_req_if;
    import clj_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
    logic [SKIP_W-1:0]       skip;

    modport source (output valid, output op, output position, output item_value,
                    output skip, input ready);
    modport sink (input valid, input op, input position, input item_value,
                  input skip, output ready);
endinterface

interface clj_rsp_if;
    import clj_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_value;
    logic [STAT_W-1:0]       status;
    logic                    last;
    logic [CNTO_W-1:0]       count_after;

    modport source (output valid, output out_value, output status, output last,
                    output count_after, input ready);
    modport sink (input valid, input out_value, input status, input last,
                  input count_after, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/clj_ram.sv =====
`default_nettype none

module clj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/clj_mod.sv =====
`default_nettype none
`include "circular_list_josephus_engine_defines.svh"

module clj_mod (
    input  logic              clk,
    input  logic              rst_n,
    input  clj_pkg::mod_req_t mreq,
    output clj_pkg::mod_rsp_t mrsp
);
    import clj_pkg::*;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [SKIP_W-1:0] dvd_reg,   dvd_next;
    logic [CNT_W-1:0]  div_reg,   div_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [CNT_W:0]    trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, dvd_reg[SKIP_W-1]};
        if (trial >= (CNT_W + 1)'(div_reg))
        begin
            trial = trial - (CNT_W + 1)'(div_reg);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (mreq.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SKIP_W);
            dvd_next  = mreq.dividend;
            div_next  = mreq.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[SKIP_W-2:0], 1'b0};
            rem_next  = trial[CNT_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign mrsp.done      = done_reg;
    assign mrsp.remainder = rem_reg;

    `CLJ_ASSERT_IMPL(a_rem_below_div, clk, rst_n, done_reg, rem_reg < div_reg)
    `CLJ_ASSERT_IMPL(a_start_idle, clk, rst_n, mreq.start, !busy_reg)
    `CLJ_ASSERT_IMPL(a_busy_steps, clk, rst_n, busy_reg, step_reg != '0)

endmodule

`default_nettype wire

// ===== hw/rtl/circular_list_josephus_engine.sv =====
// channel | dir | payload                                  | handshake
// req     | in  | op, position, item_value, skip           | valid/ready
// rsp     | out | out_value, status, last, count_after     | valid/ready
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Insert and delete also shift every element behind the target position.
// Reverse runs its swap states once per swapped pair; eliminate per removal
// waits on the remainder unit (one bit of skip a cycle) plus the tail moves.
// Element moves are bounded by the single-port-pair ring RAM, one per cycle.
// Reset empties the ring at once; no clearing pass. A held result stalls
// the sequencer only when the next result is ready to be loaded.
`default_nettype none
`include "circular_list_josephus_engine_defines.svh"

module circular_list_josephus_engine (
    input  logic     clk,
    input  logic     rst_n,
    clj_req_if.sink  req,
    clj_rsp_if.source rsp
);
    import clj_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        cnt_reg,      cnt_next;
    logic [ADDR_W-1:0]       head_reg;
    logic                    pend_reg,     pend_next;
    logic [CNT_W-1:0]        mv_cnt_reg,   mv_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    logic [OP_W-1:0]         op_reg,       op_next;
    logic [POS_W-1:0]        pos_reg,      pos_next;
    logic signed [VAL_W-1:0] val_reg,      val_next;
    logic [SKIP_W-1:0]       skip_reg,     skip_next;
    logic [ADDR_W-1:0]       off_reg,      off_next;
    logic [ADDR_W-1:0]       tgt_reg,      tgt_next;
    logic [ADDR_W-1:0]       src_reg,      src_next;
    logic [ADDR_W-1:0]       jdx_reg,      jdx_next;
    logic [ADDR_W-1:0]       wdst_reg,     wdst_next;
    logic                    up_reg,       up_next;
    logic [VAL_W-1:0]        tmp_reg,      tmp_next;

    logic signed [VAL_W-1:0] res_value_reg,  res_value_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic                    res_last_reg,   res_last_next;

    logic signed [VAL_W-1:0] out_value_reg,  out_value_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic                    out_last_reg,   out_last_next;
    logic [CNTO_W-1:0]       out_count_reg,  out_count_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    mod_req_t                mreq;
    mod_rsp_t                mrsp;

    logic [CMP_W-1:0]        cnt_ext;
    logic [CMP_W-1:0]        pos_ext;
    logic                    ring_full;
    logic                    ring_empty;
    logic                    ins_bad;
    logic                    pos_bad;
    logic                    shift_done;
    logic                    emit_ok;
    logic                    sw_more;
    logic [CNT_W:0]          rot_sum;
    logic [CNT_W:0]          rot_idx;

    clj_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    clj_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mreq),
        .mrsp  (mrsp)
    );

    assign cnt_ext    = CMP_W'(cnt_reg);
    assign pos_ext    = CMP_W'(pos_reg);
    assign ring_full  = cnt_reg >= CNT_W'(CAPACITY);
    assign ring_empty = cnt_reg == '0;
    assign ins_bad    = (pos_reg == '0) || (pos_ext > cnt_ext + CMP_W'(1));
    assign pos_bad    = (pos_reg == '0) || (pos_ext > cnt_ext);
    assign shift_done = (mv_cnt_reg == '0) && !pend_reg;
    assign emit_ok    = !out_valid_reg || rsp.ready;
    assign sw_more    = (ADDR_W + 1)'(src_reg) + (ADDR_W + 1)'(2) < (ADDR_W + 1)'(jdx_reg);

    // head of the next removal: offset plus skip mod count, wrapped once
    assign rot_sum = (CNT_W + 1)'(off_reg) + (CNT_W + 1)'(mrsp.remainder);
    assign rot_idx = (rot_sum >= (CNT_W + 1)'(cnt_reg)) ?
                     rot_sum - (CNT_W + 1)'(cnt_reg) : rot_sum;

    assign mreq.start    = state_reg == S_MOD_GO;
    assign mreq.dividend = skip_reg;
    assign mreq.divisor  = cnt_reg;

    assign req.ready       = state_reg == S_IDLE;
    assign rsp.valid       = out_valid_reg;
    assign rsp.out_value   = out_value_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.count_after = out_count_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_INSERT:  state_next = (ring_full || ins_bad) ? S_EMIT : S_SHIFT;
                    OP_DELETE:  state_next = (ring_empty || pos_bad) ? S_EMIT : S_RD;
                    OP_READ:    state_next = (ring_empty || pos_bad) ? S_EMIT : S_RD;
                    OP_REVERSE: state_next = (cnt_reg < CNT_W'(2)) ? S_EMIT : S_SW_RD0;
                    OP_ELIM:    state_next = ring_empty ? S_EMIT : S_MOD_GO;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_MOD_GO:   state_next = S_MOD_WAIT;
            S_MOD_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:       state_next = S_RD_WAIT;
            S_RD_WAIT:  state_next = (op_reg == OP_READ) ? S_EMIT : S_SHIFT;
            S_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = (op_reg == OP_INSERT) ? S_INS_WR : S_EMIT;
                end
            end
            S_INS_WR:   state_next = S_EMIT;
            S_SW_RD0:   state_next = S_SW_RD1;
            S_SW_RD1:   state_next = S_SW_WR0;
            S_SW_WR0:   state_next = S_SW_WR1;
            S_SW_WR1:   state_next = sw_more ? S_SW_RD1 : S_EMIT;
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ((op_reg == OP_ELIM) && !ring_empty) ? S_MOD_GO : S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        mv_cnt_next     = mv_cnt_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        skip_next       = skip_reg;
        off_next        = off_reg;
        tgt_next        = tgt_reg;
        src_next        = src_reg;
        jdx_next        = jdx_reg;
        wdst_next       = wdst_reg;
        up_next         = up_reg;
        tmp_next        = tmp_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.op;
                    pos_next  = req.position;
                    val_next  = req.item_value;
                    skip_next = req.skip;
                end
            end
            S_DISPATCH:
            begin
                res_value_next  = '0;
                res_status_next = ST_OK;
                res_last_next   = 1'b1;
                pend_next       = 1'b0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (ring_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else if (ins_bad)
                        begin
                            res_status_next = ST_BADPOS;
                        end
                        else
                        begin
                            mv_cnt_next = CNT_W'(cnt_ext + CMP_W'(1) - pos_ext);
                            src_next    = ADDR_W'(cnt_reg - 1'b1);
                            up_next     = 1'b1;
                        end
                    end
                    OP_DELETE, OP_READ:
                    begin
                        if (ring_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (pos_bad)
                        begin
                            res_status_next = ST_BADPOS;
                        end
                        else
                        begin
                            tgt_next = ADDR_W'(pos_reg - 1'b1);
                        end
                    end
                    OP_REVERSE:
                    begin
                        src_next = '0;
                        jdx_next = ADDR_W'(cnt_reg - 1'b1);
                    end
                    OP_ELIM:
                    begin
                        if (ring_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        off_next = '0;
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_MOD_GO:
            begin
                res_status_next = ST_OK;
            end
            S_MOD_WAIT:
            begin
                if (mrsp.done)
                begin
                    tgt_next = ADDR_W'(rot_idx);
                end
            end
            S_RD:
            begin
                ram_raddr = phys(head_reg, tgt_reg);
            end
            S_RD_WAIT:
            begin
                res_value_next = $signed(ram_rdata);
                if (op_reg == OP_ELIM)
                begin
                    res_last_next = cnt_reg == CNT_W'(1);
                end
                mv_cnt_next = CNT_W'(cnt_reg - 1'b1 - CNT_W'(tgt_reg));
                src_next    = ADDR_W'(tgt_reg + 1'b1);
                up_next     = 1'b0;
                pend_next   = 1'b0;
            end
            S_SHIFT:
            begin
                if (mv_cnt_reg != '0)
                begin
                    ram_raddr   = phys(head_reg, src_reg);
                    wdst_next   = phys(head_reg, up_reg ? ADDR_W'(src_reg + 1'b1)
                                                        : ADDR_W'(src_reg - 1'b1));
                    src_next    = up_reg ? ADDR_W'(src_reg - 1'b1) : ADDR_W'(src_reg + 1'b1);
                    mv_cnt_next = mv_cnt_reg - 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wdst_reg;
                    ram_wdata = ram_rdata;
                end
                if (shift_done && (op_reg != OP_INSERT))
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (op_reg == OP_ELIM)
                    begin
                        off_next = (CNT_W'(tgt_reg) == cnt_reg - 1'b1) ? '0 : tgt_reg;
                    end
                end
            end
            S_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, ADDR_W'(pos_reg - 1'b1));
                ram_wdata = val_reg;
                cnt_next  = cnt_reg + 1'b1;
            end
            S_SW_RD0:
            begin
                ram_raddr = phys(head_reg, src_reg);
            end
            S_SW_RD1:
            begin
                ram_raddr = phys(head_reg, jdx_reg);
                tmp_next  = ram_rdata;
            end
            S_SW_WR0:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, src_reg);
                ram_wdata = ram_rdata;
            end
            S_SW_WR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, jdx_reg);
                ram_wdata = tmp_reg;
                ram_raddr = phys(head_reg, ADDR_W'(src_reg + 1'b1));
                src_next  = src_reg + 1'b1;
                jdx_next  = jdx_reg - 1'b1;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = res_last_reg;
                    out_count_next  = CNTO_W'(cnt_reg);
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            head_reg      <= '0;
            pend_reg      <= 1'b0;
            mv_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            mv_cnt_reg    <= mv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        skip_reg       <= skip_next;
        off_reg        <= off_next;
        tgt_reg        <= tgt_next;
        src_reg        <= src_next;
        jdx_reg        <= jdx_next;
        wdst_reg       <= wdst_next;
        up_reg         <= up_next;
        tmp_reg        <= tmp_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    `CLJ_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(CAPACITY))
    `CLJ_ASSERT_IMPL(a_ins_room, clk, rst_n, state_reg == S_INS_WR, cnt_reg < CNT_W'(CAPACITY))
    `CLJ_ASSERT_IMPL(a_we_state, clk, rst_n, ram_we, (state_reg == S_SHIFT) || (state_reg == S_INS_WR) || (state_reg == S_SW_WR0) || (state_reg == S_SW_WR1))
    `CLJ_ASSERT_IMPL(a_load_emit, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_EMIT)
    `CLJ_ASSERT_NEXT(a_shift_count, clk, rst_n, (state_reg == S_SHIFT) && (mv_cnt_reg != '0), mv_cnt_reg == $past(mv_cnt_reg) - 1'b1)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
    import clj_pkg::*;

    localparam int LIMIT        = 2500000;
    localparam int RAND_ITEMS   = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [STAT_W-1:0]       status;
        logic                    last;
        logic [CNTO_W-1:0]       count;
    } ring_result_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic [SKIP_W-1:0]       skip;
        logic                    typed;
        ring_result_t            res;
    } dir_row_t;

    // typed rows carry their one result; the rest go through the ring predictor
    localparam dir_row_t DIR_TAB [0:24] = '{
        '{OP_READ,    6'd1,  32'sd0,        16'd0,    1'b1, '{32'sd0,        ST_EMPTY,  1'b1, 6'd0}},
        '{OP_DELETE,  6'd1,  32'sd0,        16'd0,    1'b1, '{32'sd0,        ST_EMPTY,  1'b1, 6'd0}},
        '{OP_ELIM,    6'd0,  32'sd0,        16'd5,    1'b1, '{32'sd0,        ST_EMPTY,  1'b1, 6'd0}},
        '{OP_REVERSE, 6'd0,  32'sd0,        16'd0,    1'b1, '{32'sd0,        ST_OK,     1'b1, 6'd0}},
        '{OP_INSERT,  6'd0,  32'sd7,        16'd0,    1'b1, '{32'sd0,        ST_BADPOS, 1'b1, 6'd0}},
        '{OP_INSERT,  6'd2,  32'sd7,        16'd0,    1'b1, '{32'sd0,        ST_BADPOS, 1'b1, 6'd0}},
        '{OP_INSERT,  6'd1,  32'h7FFFFFFF,  16'd0,    1'b1, '{32'sd0,        ST_OK,     1'b1, 6'd1}},
        '{OP_REVERSE, 6'd0,  32'sd0,        16'd0,    1'b1, '{32'sd0,        ST_OK,     1'b1, 6'd1}},
        '{OP_READ,    6'd1,  32'sd0,        16'd0,    1'b1, '{32'h7FFFFFFF,  ST_OK,     1'b1, 6'd1}},
        '{OP_READ,    6'd2,  32'sd0,        16'd0,    1'b1, '{32'sd0,        ST_BADPOS, 1'b1, 6'd1}},
        '{OP_READ,    6'd0,  32'sd0,        16'd0,    1'b1, '{32'sd0,        ST_BADPOS, 1'b1, 6'd1}},
        '{OP_INSERT,  6'd2,  32'h80000000,  16'd0,    1'b1, '{32'sd0,        ST_OK,     1'b1, 6'd2}},
        '{OP_INSERT,  6'd1,  32'hFFFFFFFF,  16'd0,    1'b1, '{32'sd0,        ST_OK,     1'b1, 6'd3}},
        '{OP_INSERT,  6'd63, 32'sd5,        16'd0,    1'b1, '{32'sd0,        ST_BADPOS, 1'b1, 6'd3}},
        '{3'd5,       6'd1,  32'sd9,        16'd1,    1'b0, '0},
        '{3'd7,       6'd63, 32'hFFFFFFFF,  16'hFFFF, 1'b0, '0},
        '{OP_INSERT,  6'd2,  32'sd0,        16'd0,    1'b0, '0},
        '{OP_REVERSE, 6'd0,  32'sd0,        16'd0,    1'b0, '0},
        '{OP_READ,    6'd4,  32'sd0,        16'd0,    1'b0, '0},
        '{OP_DELETE,  6'd1,  32'sd0,        16'd0,    1'b0, '0},
        '{OP_DELETE,  6'd63, 32'sd0,        16'd0,    1'b1, '{32'sd0,        ST_BADPOS, 1'b1, 6'd3}},
        '{OP_ELIM,    6'd0,  32'sd0,        16'd0,    1'b0, '0},
        '{OP_INSERT,  6'd1,  32'sd11,       16'd0,    1'b0, '0},
        '{OP_INSERT,  6'd2,  32'sd22,       16'd0,    1'b0, '0},
        '{OP_ELIM,    6'd0,  32'sd0,        16'hFFFF, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    clj_req_if req_ch ();
    clj_rsp_if rsp_ch ();

    circular_list_josephus_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [VAL_W-1:0] ring_q[$];
    ring_result_t            pending_results[$];

    int  mismatches    = 0;
    int  reqs_accepted = 0;
    int  ignored_ops   = 0;
    int  results_seen  = 0;
    int  full_elims    = 0;
    int  cycle_cnt     = 0;
    bit  no_gaps       = 0;
    bit  held_once     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb: errors");
        $finish;
    end

    function automatic ring_result_t mk_result(logic signed [VAL_W-1:0] value,
                                               logic [STAT_W-1:0] status,
                                               logic last, int count);
        ring_result_t r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        r.count  = CNTO_W'(count);
        return r;
    endfunction

    // apply one request to the ring and list the results it causes
    task automatic step_ring(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val,
                             input logic [SKIP_W-1:0] skip, ref ring_result_t res[$]);
        int n;
        int p;
        int rot;
        logic signed [VAL_W-1:0] v;
        n = ring_q.size();
        p = int'(pos);
        res.delete();
        case (op)
            OP_INSERT:
            begin
                if (n >= CAPACITY)
                    res.push_back(mk_result(0, ST_FULL, 1'b1, n));
                else if (p == 0 || p > n + 1)
                    res.push_back(mk_result(0, ST_BADPOS, 1'b1, n));
                else
                begin
                    ring_q.insert(p - 1, val);
                    res.push_back(mk_result(0, ST_OK, 1'b1, n + 1));
                end
            end
            OP_DELETE, OP_READ:
            begin
                if (n == 0)
                    res.push_back(mk_result(0, ST_EMPTY, 1'b1, 0));
                else if (p == 0 || p > n)
                    res.push_back(mk_result(0, ST_BADPOS, 1'b1, n));
                else
                begin
                    v = ring_q[p - 1];
                    if (op == OP_DELETE)
                        ring_q.delete(p - 1);
                    res.push_back(mk_result(v, ST_OK, 1'b1, ring_q.size()));
                end
            end
            OP_REVERSE:
            begin
                for (int i = 0; 2 * i + 1 < n; i++)
                begin
                    v = ring_q[i];
                    ring_q[i] = ring_q[n - 1 - i];
                    ring_q[n - 1 - i] = v;
                end
                res.push_back(mk_result(0, ST_OK, 1'b1, n));
            end
            OP_ELIM:
            begin
                if (n == 0)
                    res.push_back(mk_result(0, ST_EMPTY, 1'b1, 0));
                while (ring_q.size() > 0)
                begin
                    rot = int'(skip) % ring_q.size();
                    repeat (rot) ring_q.push_back(ring_q.pop_front());
                    v = ring_q.pop_front();
                    res.push_back(mk_result(v, ST_OK, ring_q.size() == 0, ring_q.size()));
                end
            end
            default: ;
        endcase
    endtask

    task automatic issue_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val,
                             input logic [SKIP_W-1:0] skip,
                             input logic typed, input ring_result_t typed_res);
        ring_result_t res[$];
        if (!no_gaps)
        begin
            while ($urandom_range(99) < 18)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.position   <= pos;
        req_ch.item_value <= val;
        req_ch.skip       <= skip;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        reqs_accepted++;
        step_ring(op, pos, val, skip, res);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (res[i]) pending_results.push_back(res[i]);
        @(negedge clk);
    endtask

    // result sink; one long hold-off once the ring is well filled
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_once && rst_n && ring_q.size() >= 24)
            begin
                held_once = 1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin : check_rsp
        ring_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected result",
                             " value=%0d status=%0d last=%0d count=%0d",
                             rsp_ch.out_value, rsp_ch.status, rsp_ch.last,
                             rsp_ch.count_after);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.out_value !== want.value || rsp_ch.status !== want.status ||
                    rsp_ch.last !== want.last || rsp_ch.count_after !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value=%0d status=%0d last=%0d count=%0d,",
                                 want.value, want.status, want.last, want.count,
                                 " got value=%0d status=%0d last=%0d count=%0d",
                                 rsp_ch.out_value, rsp_ch.status, rsp_ch.last,
                                 rsp_ch.count_after);
                end
            end
        end
    end

    initial
    begin
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic [SKIP_W-1:0]       skip;
        int  n_items;
        int  cnt;
        int  pick;
        bit  filling;
        bit  full_tried;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_INSERT;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        req_ch.skip       = '0;
        filling           = 0;
        full_tried        = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIR_TAB[i])
        begin
            issue_req(DIR_TAB[i].op, DIR_TAB[i].pos, DIR_TAB[i].val, DIR_TAB[i].skip,
                      DIR_TAB[i].typed, DIR_TAB[i].res);
            if (DIR_TAB[i].op > OP_READ)
                ignored_ops++;
        end

        n_items = 0;
        while (n_items < RAND_ITEMS)
        begin
            if (n_items == 80 || n_items == 170 || $urandom_range(99) < 2)
                filling = 1;
            no_gaps = (n_items >= 120 && n_items < 160);
            cnt  = ring_q.size();
            pos  = POS_W'($urandom);
            val  = $urandom;
            skip = SKIP_W'($urandom);
            if (filling)
            begin
                // fill to capacity, hit the full case once, then empty it
                if (cnt < CAPACITY)
                begin
                    op  = OP_INSERT;
                    pos = POS_W'($urandom_range(1, cnt + 1));
                end
                else if (!full_tried)
                begin
                    op = OP_INSERT;
                    full_tried = 1;
                end
                else
                begin
                    op = OP_ELIM;
                    filling = 0;
                    full_tried = 0;
                    full_elims++;
                end
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                    op = OP_W'($urandom_range(5, 7));
                else if (pick < 40)
                begin
                    op  = OP_INSERT;
                    pos = POS_W'($urandom_range(1, cnt + 1));
                end
                else if (pick < 72)
                begin
                    op  = (pick < 52) ? OP_DELETE : OP_READ;
                    pos = POS_W'($urandom_range(1, (cnt > 0) ? cnt : 1));
                end
                else if (pick < 80)
                    op = OP_REVERSE;
                else if (pick < 86)
                    op = OP_ELIM;
                else
                begin
                    case ($urandom_range(2))
                        0: op = OP_INSERT;
                        1: op = OP_DELETE;
                        default: op = OP_READ;
                    endcase
                    pos = ($urandom_range(1) == 0) ? '0 : POS_W'($urandom_range(cnt + 2, 63));
                end
            end
            if (op == OP_ELIM)
            begin
                case ($urandom_range(3))
                    0: skip = '0;
                    1: skip = SKIP_W'($urandom_range(1, 40));
                    default: ;
                endcase
            end
            issue_req(op, pos, val, skip, 1'b0, '0);
            if (op > OP_READ)
                ignored_ops++;
            else
                n_items++;
        end
        no_gaps = 0;
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests (%0d with unused op codes), %0d results checked",
                 reqs_accepted, ignored_ops, results_seen);
        $display("tb: %0d eliminations of a full ring, output hold-off %0s, %0d mismatches",
                 full_elims, held_once ? "done" : "missed", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== circular_list_josephus_engine.f =====
+incdir+hw/rtl
hw/rtl/clj_pkg.sv
hw/rtl/clj_if.sv
hw/rtl/clj_ram.sv
hw/rtl/clj_mod.sv
hw/rtl/circular_list_josephus_engine.sv
bench/tb.sv
